// ===== rtl/walsh_hadamard_transform_macros.svh =====
// Assertion macros used by the checker file of walsh_hadamard_transform.
`ifndef WALSH_HADAMARD_TRANSFORM_MACROS_SVH
`define WALSH_HADAMARD_TRANSFORM_MACROS_SVH

// Concurrent check on clk, off while rst_n is low.
`define WHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in this cycle, consequent in the next.
`define WHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  `WHT_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/wht_pkg.sv =====
// Shared types and constants of the Walsh-Hadamard transform block.
package wht_pkg;

  localparam int unsigned SAMPLE_W      = 32;
  localparam int unsigned COEF_W        = 38;
  localparam int unsigned BITS_W        = 3;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 3;
  localparam int unsigned MAX_BITS_DFLT = 6;
  localparam int unsigned IQ_DEPTH      = 4;
  localparam int unsigned OQ_DEPTH      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE  = 2'd1;

  localparam logic [BITS_W-1:0] NUM_BITS_RST = 3'd6;

  // Active transform setup, front to back.
  typedef struct packed {
    logic [BITS_W-1:0] bits;
    logic              inverse;
  } wht_cfg_t;

  // Classified sample in the queue between front and back.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } wht_item_t;

  // Result beat in the output queue.
  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic                     last;
  } wht_res_t;

endpackage

// ===== rtl/wht_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module wht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/wht_fifo.sv =====
// Small register FIFO with occupancy count.
module wht_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  output logic                       full,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = wptr_r + PW'(1);
    end
    if (do_rd) begin
      rptr_nxt = rptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + (PW+1)'(1);
    end else if (!do_wr && do_rd) begin
      cnt_nxt = cnt_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr_r] <= wr_data;
    end
  end

  assign rd_data = mem[rptr_r];
  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (PW+1)'(DEPTH));
  assign count   = cnt_r;

endmodule

// ===== rtl/wht_front.sv =====
// Front end: config registers, sample counting, classified sample queue.
module wht_front #(
  parameter int unsigned MAX_BITS = wht_pkg::MAX_BITS_DFLT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wht_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wht_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [wht_pkg::SAMPLE_W-1:0] in_sample,
  output wht_pkg::wht_cfg_t                   cfg,
  output wht_pkg::wht_item_t                  item,
  output logic                                item_empty,
  input  logic                                item_pop
);

  localparam int unsigned CNT_W = MAX_BITS + 1;

  logic [wht_pkg::BITS_W-1:0] num_bits_r, num_bits_nxt;
  logic                       inverse_r, inverse_nxt;
  logic [MAX_BITS-1:0]        load_cnt_r, load_cnt_nxt;
  logic [wht_pkg::BITS_W-1:0] bits;
  logic [CNT_W-1:0]           len;
  logic                       accept, is_last;
  wht_pkg::wht_item_t         push_item;

  assign cfg_ready = 1'b1;

  always_comb begin
    num_bits_nxt = num_bits_r;
    inverse_nxt  = inverse_r;
    if (cfg_valid) begin
      case (cfg_index)
        wht_pkg::REG_NUM_BITS: num_bits_nxt = cfg_data;
        wht_pkg::REG_INVERSE:  inverse_nxt  = cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp length to 1..MAX_BITS.
  always_comb begin
    if (num_bits_r == '0) begin
      bits = wht_pkg::BITS_W'(1);
    end else if (num_bits_r > wht_pkg::BITS_W'(MAX_BITS)) begin
      bits = wht_pkg::BITS_W'(MAX_BITS);
    end else begin
      bits = num_bits_r;
    end
  end

  assign len     = CNT_W'(1) << bits;
  assign accept  = in_push && !in_full;
  assign is_last = ({1'b0, load_cnt_r} + CNT_W'(1)) >= len;

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    if (accept) begin
      load_cnt_nxt = is_last ? '0 : load_cnt_r + MAX_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bits_r <= wht_pkg::NUM_BITS_RST;
      inverse_r  <= 1'b0;
      load_cnt_r <= '0;
    end else begin
      num_bits_r <= num_bits_nxt;
      inverse_r  <= inverse_nxt;
      load_cnt_r <= load_cnt_nxt;
    end
  end

  assign cfg.bits    = bits;
  assign cfg.inverse = inverse_r;

  assign push_item.sample = in_sample;
  assign push_item.last   = is_last;

  wht_fifo #(
    .WIDTH ($bits(wht_pkg::wht_item_t)),
    .DEPTH (wht_pkg::IQ_DEPTH)
  ) u_iq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_push),
    .wr_data (push_item),
    .full    (in_full),
    .rd_en   (item_pop),
    .rd_data (item),
    .empty   (item_empty),
    .count   ()
  );

endmodule

// ===== rtl/wht_back.sv =====
// Back end: work buffer, butterfly sequencer, scaling and result queue.
module wht_back #(
  parameter int unsigned MAX_BITS = wht_pkg::MAX_BITS_DFLT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wht_pkg::wht_cfg_t                  cfg,
  input  wht_pkg::wht_item_t                 item,
  input  logic                               item_empty,
  output logic                               item_pop,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic signed [wht_pkg::COEF_W-1:0]  out_coefficient,
  output logic                               out_last_out
);

  localparam int unsigned AW    = MAX_BITS;
  localparam int unsigned DEPTH = 1 << MAX_BITS;
  localparam int unsigned CNT_W = MAX_BITS + 1;
  localparam int unsigned CW    = wht_pkg::COEF_W;
  localparam int unsigned OCW   = $clog2(wht_pkg::OQ_DEPTH) + 1;

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_RD_A = 6'b000010,
    ST_RD_B = 6'b000100,
    ST_WR_A = 6'b001000,
    ST_WR_B = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [AW-1:0]              ptr_r, ptr_nxt;
  logic [AW-1:0]              idx_r, idx_nxt;
  logic [wht_pkg::BITS_W-1:0] pass_r, pass_nxt;
  logic signed [CW-1:0]       a_r, a_nxt;
  logic signed [CW-1:0]       b_r, b_nxt;
  logic                       pend_r, pend_nxt;
  logic                       pend_last_r, pend_last_nxt;

  logic [AW-1:0]              low_mask, addr_i, addr_j, half_m1, n_m1;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic signed [CW-1:0]       ram_wdata, ram_rdata;
  logic [OCW-1:0]             oq_count;
  logic                       credit;
  logic signed [CW-1:0]       round_add, scaled, adj;
  wht_pkg::wht_res_t          oq_in, oq_out;

  assign low_mask = (AW'(1) << pass_r) - AW'(1);
  assign addr_i   = ((idx_r & ~low_mask) << 1) | (idx_r & low_mask);
  assign addr_j   = addr_i | (AW'(1) << pass_r);
  assign half_m1  = (AW'(1) << (cfg.bits - wht_pkg::BITS_W'(1))) - AW'(1);
  assign n_m1     = AW'((CNT_W'(1) << cfg.bits) - CNT_W'(1));
  assign credit   = ({1'b0, oq_count} + (OCW+1)'(pend_r)) < (OCW+1)'(wht_pkg::OQ_DEPTH);

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    idx_nxt       = idx_r;
    pass_nxt      = pass_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    pend_nxt      = 1'b0;
    pend_last_nxt = pend_last_r;
    item_pop      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = addr_i;
    ram_wdata     = a_r + ram_rdata;
    ram_raddr     = addr_i;
    case (state_r)
      ST_LOAD: begin
        ram_waddr = ptr_r;
        ram_wdata = {{(CW - wht_pkg::SAMPLE_W){item.sample[wht_pkg::SAMPLE_W-1]}},
                     item.sample};
        if (!item_empty) begin
          item_pop = 1'b1;
          ram_we   = 1'b1;
          if (item.last) begin
            ptr_nxt   = '0;
            idx_nxt   = '0;
            pass_nxt  = '0;
            state_nxt = ST_RD_A;
          end else begin
            ptr_nxt = ptr_r + AW'(1);
          end
        end
      end
      ST_RD_A: begin
        state_nxt = ST_RD_B;
      end
      ST_RD_B: begin
        ram_raddr = addr_j;
        a_nxt     = ram_rdata;
        state_nxt = ST_WR_A;
      end
      ST_WR_A: begin
        ram_we    = 1'b1;
        b_nxt     = ram_rdata;
        state_nxt = ST_WR_B;
      end
      ST_WR_B: begin
        ram_we    = 1'b1;
        ram_waddr = addr_j;
        ram_wdata = a_r - b_r;
        state_nxt = ST_RD_A;
        if (idx_r == half_m1) begin
          idx_nxt = '0;
          if (pass_r == cfg.bits - wht_pkg::BITS_W'(1)) begin
            ptr_nxt   = '0;
            state_nxt = ST_EMIT;
          end else begin
            pass_nxt = pass_r + wht_pkg::BITS_W'(1);
          end
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      ST_EMIT: begin
        ram_raddr = ptr_r;
        if (credit) begin
          pend_nxt      = 1'b1;
          pend_last_nxt = (ptr_r == n_m1);
          ptr_nxt       = ptr_r + AW'(1);
          if (ptr_r == n_m1) begin
            ptr_nxt   = '0;
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      ptr_r   <= '0;
      idx_r   <= '0;
      pass_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      idx_r   <= idx_nxt;
      pass_r  <= pass_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    pend_last_r <= pend_last_nxt;
  end

  wht_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Divide by N, truncating toward zero.
  assign round_add = ram_rdata[CW-1] ? ((CW'(1) << cfg.bits) - CW'(1)) : '0;
  assign adj       = ram_rdata + round_add;
  assign scaled    = adj >>> cfg.bits;

  assign oq_in.coef = cfg.inverse ? scaled : ram_rdata;
  assign oq_in.last = pend_last_r;

  wht_fifo #(
    .WIDTH ($bits(wht_pkg::wht_res_t)),
    .DEPTH (wht_pkg::OQ_DEPTH)
  ) u_oq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (pend_r),
    .wr_data (oq_in),
    .full    (),
    .rd_en   (out_pop),
    .rd_data (oq_out),
    .empty   (out_empty),
    .count   (oq_count)
  );

  assign out_coefficient = oq_out.coef;
  assign out_last_out    = oq_out.last;

endmodule

// ===== rtl/walsh_hadamard_transform.sv =====
// Top level of the Walsh-Hadamard transform block.
//
//   channel  ports                                   beat moves
//   in       in_push / in_full, in_sample            one sample
//   out      out_pop / out_empty, out_coefficient,   one coefficient
//            out_last_out
//   cfg      cfg_valid / cfg_ready, cfg_index,       one register write
//            cfg_data
//
// Samples load into the work buffer at one per cycle, while the back end is in
// its load state, through a 4-deep queue. The transform then runs on the
// one-read one-write work buffer; each butterfly reads a, reads b, then writes
// a+b and a-b back. Samples keep queueing while a transform runs; out_empty and
// in_full stall each side on its own. Reset is synchronous and needs no clearing
// pass.
module walsh_hadamard_transform #(
  parameter int unsigned MAX_BITS = wht_pkg::MAX_BITS_DFLT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wht_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wht_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [wht_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [wht_pkg::COEF_W-1:0]   out_coefficient,
  output logic                                out_last_out
);

  wht_pkg::wht_cfg_t  cfg;
  wht_pkg::wht_item_t item;
  logic               item_empty;
  logic               item_pop;

  wht_front #(
    .MAX_BITS (MAX_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_sample  (in_sample),
    .cfg        (cfg),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop)
  );

  wht_back #(
    .MAX_BITS (MAX_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .item            (item),
    .item_empty      (item_empty),
    .item_pop        (item_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_coefficient (out_coefficient),
    .out_last_out    (out_last_out)
  );

endmodule

// ===== rtl/wht_checker.sv =====
// Port-level checks for walsh_hadamard_transform, bound to the top level.
`include "walsh_hadamard_transform_macros.svh"

module wht_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [wht_pkg::CFG_IDX_W-1:0]       cfg_index,
  input logic [wht_pkg::CFG_DATA_W-1:0]      cfg_data,
  input logic                                in_push,
  input logic                                in_full,
  input logic signed [wht_pkg::SAMPLE_W-1:0] in_sample,
  input logic                                out_empty,
  input logic                                out_pop,
  input logic signed [wht_pkg::COEF_W-1:0]   out_coefficient,
  input logic                                out_last_out
);

  `WHT_ASSERT(a_out_empty_after_reset, !$past(rst_n) |-> (out_empty && !in_full),
              "not empty after reset")

  `WHT_ASSERT(a_cfg_always_ready, cfg_valid |-> cfg_ready, "config write stalled")

  `WHT_ASSERT_NEXT(a_out_hold, (!out_empty && !out_pop),
                   (!out_empty && $stable({out_coefficient, out_last_out})),
                   "waiting result changed")

  `WHT_ASSERT(a_out_known, !out_empty |-> !$isunknown({out_coefficient, out_last_out}),
              "unknown result beat")

  `WHT_ASSERT(a_in_known, (in_push || cfg_valid) |-> !$isunknown({in_sample, cfg_index, cfg_data}),
              "unknown input beat")

endmodule

bind walsh_hadamard_transform wht_checker u_wht_checker (.*);

// ===== tb/walsh_hadamard_transform_tb.sv =====
// Self-checking testbench of the Walsh-Hadamard transform block.
module walsh_hadamard_transform_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETTLE_CYCLES = 1500;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned RAND_ITEMS    = 160;
  localparam int unsigned MAX_SHOWN     = 10;
  localparam int unsigned CW            = wht_pkg::COEF_W;

  class hadamard_scoreboard;
    logic [wht_pkg::BITS_W-1:0]        num_bits_reg;
    logic                              inverse_reg;
    logic signed [wht_pkg::COEF_W-1:0] vec [64];
    int unsigned                       fill;
    wht_pkg::wht_res_t                 coef_due_q [$];
    int unsigned                       errors;

    function new();
      num_bits_reg = wht_pkg::NUM_BITS_RST;
      inverse_reg  = 1'b0;
      fill         = 0;
      errors       = 0;
    endfunction

    function void write_reg(logic [wht_pkg::CFG_IDX_W-1:0] idx,
                            logic [wht_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        wht_pkg::REG_NUM_BITS: num_bits_reg = data;
        wht_pkg::REG_INVERSE:  inverse_reg  = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return coef_due_q.size();
    endfunction

    // Loads one sample; a full vector yields its transformed coefficients.
    function void note_sample(logic signed [wht_pkg::SAMPLE_W-1:0] s);
      int unsigned                       bits;
      int unsigned                       n;
      int unsigned                       span;
      logic signed [wht_pkg::COEF_W-1:0] a;
      logic signed [wht_pkg::COEF_W-1:0] b;
      logic signed [wht_pkg::COEF_W-1:0] len;
      wht_pkg::wht_res_t                 r;
      bits = (num_bits_reg == 0) ? 1 : ((num_bits_reg > 6) ? 6 : int'(num_bits_reg));
      n = 1 << bits;
      vec[fill & 63] = CW'(s);
      fill = (fill + 1) & 127;
      if (fill < n) return;
      fill = 0;
      for (int k = 0; k < bits; k++) begin
        span = 1 << k;
        for (int i = 0; i < n; i++) begin
          if ((i & span) == 0) begin
            a = vec[i];
            b = vec[i | span];
            vec[i] = a + b;
            vec[i | span] = a - b;
          end
        end
      end
      len = CW'(n);
      for (int i = 0; i < n; i++) begin
        r.coef = inverse_reg ? vec[i] / len : vec[i];
        r.last = (i == n - 1);
        coef_due_q.insert(coef_due_q.size(), r);
      end
    endfunction

    function void check_coef(logic signed [wht_pkg::COEF_W-1:0] coef, logic last);
      wht_pkg::wht_res_t r;
      if (coef_due_q.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("unexpected beat: coefficient %0d last %0b", coef, last);
        return;
      end
      r = coef_due_q.pop_front();
      if (r.coef !== coef || r.last !== last) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("mismatch: expected coefficient %0d last %0b, got %0d last %0b",
                   r.coef, r.last, coef, last);
      end
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [wht_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [wht_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
  logic                                in_push = 1'b0;
  logic                                in_full;
  logic signed [wht_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic                                out_empty;
  logic                                out_pop = 1'b0;
  logic signed [wht_pkg::COEF_W-1:0]   out_coefficient;
  logic                                out_last_out;

  hadamard_scoreboard sb = new();
  int unsigned        tx_idle_pct = 37;
  int unsigned        rx_idle_pct = 62;
  bit                 hold_req = 1'b0;

  walsh_hadamard_transform dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_sample       (in_sample),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_coefficient (out_coefficient),
    .out_last_out    (out_last_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic signed [wht_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 15)) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_sample(input logic signed [wht_pkg::SAMPLE_W-1:0] v);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push   <= 1'b1;
    in_sample <= v;
    do @(posedge clk); while (in_full);
    sb.note_sample(v);
    @(negedge clk);
  endtask

  task automatic set_transform(input logic [wht_pkg::CFG_DATA_W-1:0] bits, input logic inv);
    cfg_valid <= 1'b1;
    cfg_index <= wht_pkg::REG_NUM_BITS;
    cfg_data  <= bits;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(wht_pkg::REG_NUM_BITS, bits);
    @(negedge clk);
    cfg_index <= wht_pkg::REG_INVERSE;
    cfg_data  <= {{(wht_pkg::CFG_DATA_W-1){1'b0}}, inv};
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(wht_pkg::REG_INVERSE, {{(wht_pkg::CFG_DATA_W-1){1'b0}}, inv});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Result side: random pops, plus one long hold-off on request.
  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      @(posedge clk);
      if (out_pop && !out_empty) sb.check_coef(out_coefficient, out_last_out);
    end
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned rand_items;
    int unsigned nb;
    int unsigned cnt;
    bit          first;
    rand_items = 0;
    first = 1'b1;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_transform(3'd1, 1'b0);
    push_sample(32'sh7fffffff); push_sample(32'sh7fffffff);
    push_sample(32'sh80000000); push_sample(32'sh80000000);
    push_sample(32'sh7fffffff); push_sample(32'sh80000000);
    wait_idle();
    // inverse: truncation toward zero on both signs
    set_transform(3'd1, 1'b1);
    push_sample(32'sh80000000); push_sample(32'sh7fffffff);
    push_sample(-32'sd1); push_sample(32'sd0);
    push_sample(32'sd3); push_sample(-32'sd2);
    push_sample(-32'sd3); push_sample(32'sd0);
    wait_idle();
    // length zero acts as two
    set_transform(3'd0, 1'b0);
    push_sample(32'sd5); push_sample(-32'sd7);
    wait_idle();
    set_transform(3'd2, 1'b1);
    push_sample(-32'sd1); push_sample(-32'sd2); push_sample(-32'sd3); push_sample(-32'sd4);
    // shrink the length with a partial vector loaded
    push_sample(32'sd7); push_sample(-32'sd8); push_sample(32'sd9);
    wait_idle();
    set_transform(3'd1, 1'b1);
    push_sample(32'sd11);

    // back pressure: receiver holds off while the sender keeps pushing
    wait_idle();
    set_transform(3'd3, 1'($urandom_range(0, 1)));
    tx_idle_pct = 0;
    hold_req = 1'b1;
    repeat (40) push_sample(rand_sample());
    rand_items += 40;

    while (rand_items < RAND_ITEMS) begin
      case (rand_items * 3 / RAND_ITEMS)
        0: begin tx_idle_pct = 37; rx_idle_pct = 62; end
        1: begin tx_idle_pct = 62; rx_idle_pct = 37; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      wait_idle();
      if (first) nb = 7;
      else if ($urandom_range(0, 5) == 0) nb = $urandom_range(0, 7);
      else nb = $urandom_range(0, 3);
      set_transform(nb[2:0], 1'($urandom_range(0, 1)));
      if (first) cnt = 64;
      else begin
        cnt = 3 << ((nb == 0) ? 1 : ((nb > 6) ? 6 : nb));
        cnt = $urandom_range(1, (cnt > 48) ? 48 : cnt);
      end
      first = 1'b0;
      repeat (cnt) push_sample(rand_sample());
      rand_items += cnt;
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wht_pkg.sv
rtl/wht_ram.sv
rtl/wht_fifo.sv
rtl/wht_front.sv
rtl/wht_back.sv
rtl/walsh_hadamard_transform.sv
rtl/wht_checker.sv
tb/walsh_hadamard_transform_tb.sv
